@@ hw/rtl/teq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Touch event queue package
// Field widths, operation and status codes, and the entry layout used by the
// queue; its channel interfaces share the field widths.
// ----------------------------------------------------------------------------
package teq_pkg;

   // Field widths of one event and one result.
   localparam int ActW    = 2;
   localparam int SlotW   = 4;
   localparam int CoordW  = 16;
   localparam int StampW  = 32;
   localparam int StatusW = 3;
   localparam int CountW  = 32;

   // Stored entry layout: position word {x, y} and meta word {action, slot, stamp}.
   localparam int PosW  = 2 * CoordW;
   localparam int MetaW = ActW + SlotW + StampW;

   // Request operations.
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   // Event kind that may be coalesced or overwritten.
   localparam logic [ActW-1:0] ACT_MOVE = 2'd0;

   // Result status codes.
   typedef enum logic [StatusW-1:0] {
      ST_STORED    = 3'd0,
      ST_MERGED    = 3'd1,
      ST_OVERWROTE = 3'd2,
      ST_DROPPED   = 3'd3,
      ST_POPPED    = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

endpackage
`default_nettype wire

@@ hw/rtl/teq_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Touch event queue channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------

// Request channel: push an event or pop the oldest one.
interface teq_req_if import teq_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [ActW-1:0]   action;
   logic [SlotW-1:0]  slot;
   logic [CoordW-1:0] pos_x;
   logic [CoordW-1:0] pos_y;
   logic [StampW-1:0] stamp;

   modport source (output valid, opcode, action, slot, pos_x, pos_y, stamp,
                   input ready);
   modport sink   (input valid, opcode, action, slot, pos_x, pos_y, stamp,
                   output ready);
endinterface

// Response channel: one beat per request.
interface teq_rsp_if import teq_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [StatusW-1:0] status;
   logic [ActW-1:0]    out_action;
   logic [SlotW-1:0]   out_slot;
   logic [CoordW-1:0]  out_x;
   logic [CoordW-1:0]  out_y;
   logic [StampW-1:0]  out_stamp;
   logic [CountW-1:0]  drop_total;

   modport source (output valid, status, out_action, out_slot, out_x, out_y,
                   out_stamp, drop_total, input ready);
   modport sink   (input valid, status, out_action, out_slot, out_x, out_y,
                   out_stamp, drop_total, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/touch_event_queue_with_coalescing_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Touch event queue with coalescing
// Ring FIFO of touch events that, on overflow, coalesces into the tail,
// overwrites an older move or drops the event; held in two synchronous RAMs.
// ----------------------------------------------------------------------------
// The queue takes one request beat at a time and answers each with exactly
// one response beat. A push into a queue with room, and a pop of an empty
// queue, go straight from idle to done; a pop that returns an event also
// passes through the check state, since the entry is read from a RAM with a
// registered read port. A push into a full queue reads the newest entries
// one per cycle, newest first, in the check state, examining up to SCAN_DEPTH
// (or CAPACITY if smaller) entries. The response waits in an output register,
// so the next request is accepted while a finished response is still held by
// the sink. Stored entries are undefined until written; only entries the
// queue currently holds are ever used, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module touch_event_queue_with_coalescing_unit
   import teq_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int SCAN_DEPTH = 8
) (
   input wire logic clock,
   input wire logic reset,
   teq_req_if.sink   req_bus,
   teq_rsp_if.source rsp_bus
);

   localparam int IdxW    = $clog2(CAPACITY);
   localparam int ScanLen = (SCAN_DEPTH < CAPACITY) ? SCAN_DEPTH : CAPACITY;
   localparam int StepW   = (ScanLen > 1) ? $clog2(ScanLen) : 1;
   localparam logic [IdxW-1:0]   LastIdx  = IdxW'(CAPACITY - 1);
   localparam logic [StepW-1:0]  LastStep = StepW'(ScanLen - 1);
   localparam logic [CountW-1:0] CountMax = '1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DONE
   } state_type;

   // Control state.
   state_type         state_ff, state_in;
   logic [IdxW-1:0]   ridx_ff, ridx_in;
   logic              rlap_ff, rlap_in;
   logic [IdxW-1:0]   widx_ff, widx_in;
   logic              wlap_ff, wlap_in;
   logic [CountW-1:0] drop_ff, drop_in;
   logic [IdxW-1:0]   scan_idx_ff, scan_idx_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Latched request payload.
   op_type            op_ff, op_in;
   logic [ActW-1:0]   act_ff, act_in;
   logic [SlotW-1:0]  slot_ff, slot_in;
   logic [CoordW-1:0] px_ff, px_in;
   logic [CoordW-1:0] py_ff, py_in;
   logic [StampW-1:0] stamp_ff, stamp_in;

   // Pending result.
   status_type        res_status_ff, res_status_in;
   logic [ActW-1:0]   res_act_ff, res_act_in;
   logic [SlotW-1:0]  res_slot_ff, res_slot_in;
   logic [CoordW-1:0] res_x_ff, res_x_in;
   logic [CoordW-1:0] res_y_ff, res_y_in;
   logic [StampW-1:0] res_stamp_ff, res_stamp_in;

   // Output register.
   status_type        out_status_ff, out_status_in;
   logic [ActW-1:0]   out_act_ff, out_act_in;
   logic [SlotW-1:0]  out_slot_ff, out_slot_in;
   logic [CoordW-1:0] out_x_ff, out_x_in;
   logic [CoordW-1:0] out_y_ff, out_y_in;
   logic [StampW-1:0] out_stamp_ff, out_stamp_in;
   logic [CountW-1:0] out_drop_ff, out_drop_in;

   // RAM ports.
   logic              ram_we;
   logic [IdxW-1:0]   ram_wr_addr;
   logic [IdxW-1:0]   ram_rd_addr;
   logic [PosW-1:0]   ram_wr_pos;
   logic [MetaW-1:0]  ram_wr_meta;
   logic [PosW-1:0]   ram_rd_pos;
   logic [MetaW-1:0]  ram_rd_meta;

   // Decoded status and entry fields.
   logic              req_fire;
   logic              q_empty;
   logic              q_full;
   logic [IdxW-1:0]   newest_idx;
   logic [IdxW-1:0]   prev_scan_idx;
   logic [ActW-1:0]   ent_act;
   logic [SlotW-1:0]  ent_slot;
   logic              slot_hit;
   logic              tail_merge;
   logic [CountW-1:0] drop_next;

   teq_ram #(
      .WIDTH (PosW),
      .DEPTH (CAPACITY)
   ) u_position_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_pos),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_pos)
   );

   teq_ram #(
      .WIDTH (MetaW),
      .DEPTH (CAPACITY)
   ) u_meta_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_meta),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_meta)
   );

   // Occupancy from index and lap bit of each pointer.
   assign q_empty = (ridx_ff == widx_ff) && (rlap_ff == wlap_ff);
   assign q_full  = (ridx_ff == widx_ff) && (rlap_ff != wlap_ff);

   // Ring neighbors of the tail and of the current scan position.
   assign newest_idx    = (widx_ff == '0) ? LastIdx : widx_ff - IdxW'(1);
   assign prev_scan_idx = (scan_idx_ff == '0) ? LastIdx : scan_idx_ff - IdxW'(1);

   // Compare the entry just read against the pending push.
   assign ent_act    = ram_rd_meta[MetaW-1 -: ActW];
   assign ent_slot   = ram_rd_meta[StampW +: SlotW];
   assign slot_hit   = (ent_act == ACT_MOVE) && (ent_slot == slot_ff);
   assign tail_merge = slot_hit && (step_ff == '0) && (act_ff == ACT_MOVE);
   assign drop_next  = (drop_ff == CountMax) ? drop_ff : drop_ff + CountW'(1);

   assign req_fire = req_bus.valid && req_bus.ready;

   // Next-state and RAM control.
   always_comb begin
      state_in      = state_ff;
      ridx_in       = ridx_ff;
      rlap_in       = rlap_ff;
      widx_in       = widx_ff;
      wlap_in       = wlap_ff;
      drop_in       = drop_ff;
      scan_idx_in   = scan_idx_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      op_in         = op_ff;
      act_in        = act_ff;
      slot_in       = slot_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      stamp_in      = stamp_ff;

      res_status_in = res_status_ff;
      res_act_in    = res_act_ff;
      res_slot_in   = res_slot_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_stamp_in  = res_stamp_ff;

      out_status_in = out_status_ff;
      out_act_in    = out_act_ff;
      out_slot_in   = out_slot_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_stamp_in  = out_stamp_ff;
      out_drop_in   = out_drop_ff;

      ram_we        = 1'b0;
      ram_wr_addr   = scan_idx_ff;
      ram_rd_addr   = prev_scan_idx;
      ram_wr_pos    = {px_ff, py_ff};
      ram_wr_meta   = {act_ff, slot_ff, stamp_ff};

      unique case (state_ff)
         S_IDLE: begin
            // Start the read a pop or an overflow scan will need.
            ram_rd_addr = (req_bus.opcode == OP_POP) ? ridx_ff : newest_idx;
            ram_wr_addr = widx_ff;
            ram_wr_pos  = {req_bus.pos_x, req_bus.pos_y};
            ram_wr_meta = {req_bus.action, req_bus.slot, req_bus.stamp};
            if (req_fire) begin
               op_in        = op_type'(req_bus.opcode);
               act_in       = req_bus.action;
               slot_in      = req_bus.slot;
               px_in        = req_bus.pos_x;
               py_in        = req_bus.pos_y;
               stamp_in     = req_bus.stamp;
               res_act_in   = '0;
               res_slot_in  = '0;
               res_x_in     = '0;
               res_y_in     = '0;
               res_stamp_in = '0;
               step_in      = '0;
               scan_idx_in  = newest_idx;
               if (req_bus.opcode == OP_POP) begin
                  if (q_empty) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_CHECK;
                  end
               end else if (!q_full) begin
                  // Append at the tail.
                  ram_we        = 1'b1;
                  widx_in       = (widx_ff == LastIdx) ? '0 : widx_ff + IdxW'(1);
                  wlap_in       = (widx_ff == LastIdx) ? !wlap_ff : wlap_ff;
                  res_status_in = ST_STORED;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end

         S_CHECK: begin
            if (op_ff == OP_POP) begin
               // Return the oldest entry and advance the head.
               res_act_in    = ent_act;
               res_slot_in   = ent_slot;
               res_x_in      = ram_rd_pos[PosW-1 -: CoordW];
               res_y_in      = ram_rd_pos[CoordW-1:0];
               res_stamp_in  = ram_rd_meta[StampW-1:0];
               res_status_in = ST_POPPED;
               ridx_in       = (ridx_ff == LastIdx) ? '0 : ridx_ff + IdxW'(1);
               rlap_in       = (ridx_ff == LastIdx) ? !rlap_ff : rlap_ff;
               state_in      = S_DONE;
            end else if (slot_hit) begin
               // Coalesce into the tail or replace an older move whole.
               ram_we   = 1'b1;
               state_in = S_DONE;
               if (tail_merge) begin
                  res_status_in = ST_MERGED;
               end else begin
                  res_status_in = ST_OVERWROTE;
                  drop_in       = drop_next;
               end
            end else if (step_ff == LastStep) begin
               res_status_in = ST_DROPPED;
               drop_in       = drop_next;
               state_in      = S_DONE;
            end else begin
               // Step to the next older entry; its read is already issued.
               step_in     = step_ff + StepW'(1);
               scan_idx_in = prev_scan_idx;
            end
         end

         S_DONE: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_act_in    = res_act_ff;
               out_slot_in   = res_slot_ff;
               out_x_in      = res_x_ff;
               out_y_in      = res_y_ff;
               out_stamp_in  = res_stamp_ff;
               out_drop_in   = drop_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ridx_ff      <= '0;
         rlap_ff      <= 1'b0;
         widx_ff      <= '0;
         wlap_ff      <= 1'b0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ridx_ff      <= ridx_in;
         rlap_ff      <= rlap_in;
         widx_ff      <= widx_in;
         wlap_ff      <= wlap_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff   <= scan_idx_in;
      step_ff       <= step_in;
      op_ff         <= op_in;
      act_ff        <= act_in;
      slot_ff       <= slot_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      stamp_ff      <= stamp_in;
      res_status_ff <= res_status_in;
      res_act_ff    <= res_act_in;
      res_slot_ff   <= res_slot_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_stamp_ff  <= res_stamp_in;
      out_status_ff <= out_status_in;
      out_act_ff    <= out_act_in;
      out_slot_ff   <= out_slot_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_stamp_ff  <= out_stamp_in;
      out_drop_ff   <= out_drop_in;
   end

   // Channel outputs.
   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = out_status_ff;
   assign rsp_bus.out_action = out_act_ff;
   assign rsp_bus.out_slot   = out_slot_ff;
   assign rsp_bus.out_x      = out_x_ff;
   assign rsp_bus.out_y      = out_y_ff;
   assign rsp_bus.out_stamp  = out_stamp_ff;
   assign rsp_bus.drop_total = out_drop_ff;

   // The drop counter never goes backward.
   a_drop_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> drop_ff >= $past(drop_ff))
      else $error("drop counter decreased");

   // Entries are rewritten in place only while the queue is full.
   a_rewrite_when_full: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == S_CHECK) |-> q_full)
      else $error("in-place rewrite with room in the queue");

   // The overflow scan never runs past its limit.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && op_ff == OP_PUSH) |-> step_ff <= LastStep)
      else $error("overflow scan ran past its limit");

endmodule
`default_nettype wire

@@ hw/rtl/teq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module teq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
